>>> sv/form_field_extract_decode_assert.svh
// assertion macros shared by the checker of the form field decoder
// depends on nothing; the including module provides i_clk and i_rst_n
`ifndef FORM_FIELD_EXTRACT_DECODE_ASSERT_SVH
`define FORM_FIELD_EXTRACT_DECODE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define FFED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define FFED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ffed_pkg.sv
// shared types, character codes and helpers of the form field decoder
// no dependencies
package ffed_pkg;

    localparam int RAW_VALUE_LIMIT = 160;
    localparam int KEY_MAX_BYTES   = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_DATA        = 3;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;
    localparam logic [1:0] REG_CAPACITY = 2'd3;

    typedef enum logic [1:0] {
        PH_COMPARE,
        PH_VALUE,
        PH_SKIP,
        PH_DONE
    } t_phase;

    // results of one accepted byte: up to three data bytes, then maybe a status
    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] data;
        logic [1:0]               n_data;
        logic                     status;
        logic                     found;
    } t_entry;

    function automatic logic is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nib(logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

>>> sv/ffed_front.sv
// front end: config registers, segment/key matching and url decoding
// depends on ffed_pkg; pushes one t_entry per byte that yields results
module ffed_front import ffed_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_eob,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_push_entry
);

    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] data;
        logic [1:0]               n;
    } t_cand;

    function automatic t_cand push(t_cand c, logic [7:0] x);
        t_cand r;
        r = c;
        if (c.n != 2'd3) begin
            r.data[c.n] = x;
        end
        r.n = c.n + 2'd1;
        return r;
    endfunction

    logic [63:0] r_key_lo;
    logic [63:0] r_key_hi;
    logic [4:0]  r_key_len;
    logic [7:0]  r_cap;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_seg_pos, n_seg_pos;
    logic        r_match, n_match;
    logic [7:0]  r_raw, n_raw;
    logic [7:0]  r_emitted, n_emitted;
    logic        r_pct, n_pct;
    logic [7:0]  r_held, n_held;
    logic        r_held_v, n_held_v;
    logic        r_found, n_found;

    logic        accept;
    logic [4:0]  klen;
    logic [7:0]  key_byte;
    logic        b_amp, b_eq, b_plus, b_pct, b_hex;
    logic        in_key;
    logic        enter_value;
    logic        limit_hit;
    t_cand       cand;
    logic [8:0]  cap_need;
    logic [8:0]  avail;
    logic [1:0]  n_emit;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= '0;
            r_cap     <= 8'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:  r_key_lo  <= i_cfg_wdata;
                REG_KEY_HIGH: r_key_hi  <= i_cfg_wdata;
                REG_KEY_LEN:  r_key_len <= i_cfg_wdata[4:0];
                REG_CAPACITY: r_cap     <= i_cfg_wdata[7:0];
            endcase
        end
    end

    // shared decisions
    always_comb begin
        klen     = (r_key_len > 5'(KEY_MAX_BYTES)) ? 5'(KEY_MAX_BYTES) : r_key_len;
        key_byte = r_seg_pos[3] ? r_key_hi[{r_seg_pos[2:0], 3'b000} +: 8]
                                : r_key_lo[{r_seg_pos[2:0], 3'b000} +: 8];
        b_amp    = (i_in_byte == CH_AMP);
        b_eq     = (i_in_byte == CH_EQ);
        b_plus   = (i_in_byte == CH_PLUS);
        b_pct    = (i_in_byte == CH_PCT);
        b_hex    = is_hex(i_in_byte);
        in_key   = (r_seg_pos < klen);
        enter_value = (r_phase == PH_COMPARE) && !b_amp && !in_key && r_match && b_eq;
        limit_hit   = ((r_raw + 8'd1) >= 8'(RAW_VALUE_LIMIT - 1));
    end

    // outputs: decoded bytes of this transaction
    always_comb begin
        cand = '0;
        if (r_phase == PH_VALUE) begin
            if (b_amp) begin
                if (r_pct) begin
                    cand = push(cand, CH_PCT);
                    if (r_held_v) begin
                        cand = push(cand, r_held);
                    end
                end
            end else if (r_pct && !r_held_v && b_hex) begin
                // first hex digit held; flushed literally if the value ends here
                if (limit_hit || i_in_eob) begin
                    cand = push(cand, CH_PCT);
                    cand = push(cand, i_in_byte);
                end
            end else if (r_pct && r_held_v && b_hex) begin
                cand = push(cand, {hex_nib(r_held), hex_nib(i_in_byte)});
            end else begin
                if (r_pct) begin
                    cand = push(cand, CH_PCT);
                    if (r_held_v) begin
                        cand = push(cand, r_held);
                    end
                end
                if (b_plus) begin
                    cand = push(cand, CH_SPACE);
                end else if (!b_pct) begin
                    cand = push(cand, i_in_byte);
                end else if (limit_hit || i_in_eob) begin
                    cand = push(cand, CH_PCT);
                end
            end
        end

        // emit stops at capacity minus one
        cap_need = {1'b0, r_emitted} + 9'd1;
        avail    = ({1'b0, r_cap} > cap_need) ? ({1'b0, r_cap} - cap_need) : 9'd0;
        n_emit   = (avail < {7'd0, cand.n}) ? avail[1:0] : cand.n;

        o_push                = accept && ((n_emit != 2'd0) || i_in_eob);
        o_push_entry.data     = cand.data;
        o_push_entry.n_data   = n_emit;
        o_push_entry.status   = i_in_eob;
        o_push_entry.found    = r_found || enter_value;
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_seg_pos = r_seg_pos;
        n_match   = r_match;
        n_raw     = r_raw;
        n_emitted = r_emitted + {6'd0, n_emit};
        n_pct     = r_pct;
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_found   = r_found || enter_value;
        unique case (r_phase)
            PH_COMPARE: begin
                if (b_amp) begin
                    n_seg_pos = '0;
                    n_match   = 1'b1;
                end else if (in_key) begin
                    if (i_in_byte != key_byte) begin
                        n_match = 1'b0;
                    end
                    n_seg_pos = r_seg_pos + 5'd1;
                end else if (enter_value) begin
                    n_phase   = PH_VALUE;
                    n_raw     = '0;
                    n_emitted = '0;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (b_amp) begin
                    n_phase   = PH_COMPARE;
                    n_seg_pos = '0;
                    n_match   = 1'b1;
                end
            end
            PH_VALUE: begin
                if (b_amp || limit_hit) begin
                    n_phase  = PH_DONE;
                    n_pct    = 1'b0;
                    n_held_v = 1'b0;
                    n_held   = '0;
                end else if (r_pct && !r_held_v && b_hex) begin
                    n_held   = i_in_byte;
                    n_held_v = 1'b1;
                end else if (r_pct && r_held_v && b_hex) begin
                    n_pct    = 1'b0;
                    n_held_v = 1'b0;
                    n_held   = '0;
                end else begin
                    n_pct    = b_pct;
                    n_held_v = 1'b0;
                    n_held   = '0;
                end
                if (!b_amp) begin
                    n_raw = r_raw + 8'd1;
                end
            end
            PH_DONE: begin
            end
        endcase
        if (i_in_eob) begin
            n_phase   = PH_COMPARE;
            n_seg_pos = '0;
            n_match   = 1'b1;
            n_raw     = '0;
            n_emitted = '0;
            n_pct     = 1'b0;
            n_held    = '0;
            n_held_v  = 1'b0;
            n_found   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_COMPARE;
            r_seg_pos <= '0;
            r_match   <= 1'b1;
            r_raw     <= '0;
            r_emitted <= '0;
            r_pct     <= 1'b0;
            r_held    <= '0;
            r_held_v  <= 1'b0;
            r_found   <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_seg_pos <= n_seg_pos;
            r_match   <= n_match;
            r_raw     <= n_raw;
            r_emitted <= n_emitted;
            r_pct     <= n_pct;
            r_held    <= n_held;
            r_held_v  <= n_held_v;
            r_found   <= n_found;
        end
    end

endmodule

>>> sv/ffed_queue.sv
// short queue of result groups between front and back end
// depends on ffed_pkg
module ffed_queue import ffed_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_head_valid,
    output t_entry o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                do_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> sv/ffed_back.sv
// back end: walks the head group of the queue, one result per transaction
// depends on ffed_pkg
module ffed_back import ffed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_is_status,
    output logic       o_found,
    output logic       o_last
);

    logic [1:0] r_idx, n_idx;
    logic [2:0] total;
    logic       is_data;
    logic       take;

    always_comb begin
        total       = {1'b0, i_head.n_data} + {2'd0, i_head.status};
        is_data     = (r_idx < i_head.n_data);
        o_valid     = i_head_valid;
        o_byte      = is_data ? i_head.data[r_idx] : 8'd0;
        o_is_status = !is_data;
        o_found     = !is_data && i_head.found;
        o_last      = ({1'b0, r_idx} == (total - 3'd1));
        take        = o_valid && i_ready;
        o_pop       = take && o_last;
        n_idx       = r_idx;
        if (take) begin
            n_idx = o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

>>> sv/form_field_extract_decode.sv
// Form field decoder: takes a urlencoded body one byte per cycle while the
// queue is not full, picks the first segment whose key matches the configured
// key and emits its url-decoded value, then one status result at the end of
// the body. The back end hands out one result per cycle while m_axis_tready is
// high, so a byte that yields two to four results (escape flushes, status at
// end of body) holds the output for each of them, and a 4-entry queue of result
// groups between front and back end absorbs such bursts before s_axis_tready
// drops. The results of an accepted byte are registered in the queue first.
// Write configuration only while no results are outstanding.
// depends on ffed_pkg, ffed_front, ffed_queue, ffed_back
module form_field_extract_decode import ffed_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
    input  logic        s_axis_tlast,   // end_of_body
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] found, rest zero
    output logic        m_axis_tuser,   // [0] is_status
    output logic        m_axis_tlast    // last
);

    logic       push;
    t_entry     push_entry;
    logic       full;
    logic       pop;
    logic       head_valid;
    t_entry     head;
    logic [7:0] out_byte;
    logic       found;

    ffed_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_eob     (s_axis_tlast),
        .i_full       (full),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    ffed_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    ffed_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (out_byte),
        .o_is_status  (m_axis_tuser),
        .o_found      (found),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, found, out_byte};

endmodule

>>> sv/ffed_checker.sv
// port-level checks of the form field decoder, bound to the top level
// depends on form_field_extract_decode_assert.svh
`include "form_field_extract_decode_assert.svh"

module ffed_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result keeps its contents
    `FFED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

    // status always closes the group of its transaction
    `FFED_ASSERT_NOW(a_status_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "status result without last")

    `FFED_ASSERT_NOW(a_status_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == 8'd0, "status result carries a data byte")

    `FFED_ASSERT_NOW(a_data_nofound, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:8] == 8'd0, "data result carries found or upper bits")

endmodule

bind form_field_extract_decode ffed_checker u_ffed_checker (.*);
